// File: rtl/core/lsc_pkg.sv
// Shared constants, types and controller codes for the LRU slot cache.
`timescale 1ns / 1ps
package lsc_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_W           = 32;
	localparam int DATA_W          = 64;
	localparam int SLOT_W          = 4;
	localparam int CAP_W           = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic REQ_PUT = 1'b0;
	localparam logic REQ_GET = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} lsc_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} lsc_cmd_t;

endpackage

// File: rtl/core/lsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/lsc_ctrl.sv
// Request sequencer: accept, execute, respond, plus output valid tracking.
`timescale 1ns / 1ps
module lsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lsc_pkg::lsc_cmd_t cmd
);

	lsc_pkg::lsc_state_t state_q, state_d;
	logic                out_valid_q;
	logic                load_ok;

	assign load_ok = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lsc_pkg::S_IDLE: begin
				if (in_valid) state_d = lsc_pkg::S_EXEC;
			end
			lsc_pkg::S_EXEC: begin
				state_d = lsc_pkg::S_RESP;
			end
			lsc_pkg::S_RESP: begin
				if (load_ok) state_d = in_valid ? lsc_pkg::S_EXEC : lsc_pkg::S_IDLE;
			end
			default: begin
				state_d = lsc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			lsc_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			lsc_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			lsc_pkg::S_RESP: begin
				in_ready    = load_ok;
				cmd.capture = in_valid && load_ok;
				cmd.load    = load_ok;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/lsc_dp.sv
// Datapath: key match, recency ranks, fill count, slot data RAM, result register.
`timescale 1ns / 1ps
module lsc_dp #(
	parameter int MAX_ENTRIES = lsc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lsc_pkg::lsc_cmd_t          cmd,
	input  logic                       cfg_we,
	input  logic [lsc_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic                       req_type,
	input  logic [lsc_pkg::KEY_W-1:0]  key,
	input  logic [lsc_pkg::DATA_W-1:0] value,
	output logic                       hit,
	output logic [lsc_pkg::SLOT_W-1:0] slot,
	output logic [lsc_pkg::DATA_W-1:0] read_data,
	output logic                       evicted,
	output logic [lsc_pkg::KEY_W-1:0]  evicted_key
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EW    = (CNT_W > lsc_pkg::CAP_W) ? CNT_W : lsc_pkg::CAP_W;

	logic [lsc_pkg::CAP_W-1:0]  capacity_q;
	logic [CNT_W-1:0]           fill_q;
	logic [lsc_pkg::KEY_W-1:0]  keys_q  [MAX_ENTRIES];
	logic [IDX_W-1:0]           ranks_q [MAX_ENTRIES];

	logic                       req_type_q;
	logic [lsc_pkg::KEY_W-1:0]  key_q;
	logic [lsc_pkg::DATA_W-1:0] value_q;
	logic [MAX_ENTRIES-1:0]     match_s1;
	logic [MAX_ENTRIES-1:0]     victim_s1;

	logic                       hit_s2;
	logic                       get_hit_s2;
	logic [lsc_pkg::SLOT_W-1:0] slot_s2;
	logic                       evicted_s2;
	logic [lsc_pkg::KEY_W-1:0]  evkey_s2;

	logic [IDX_W-1:0]           last_rank;
	logic [MAX_ENTRIES-1:0]     occ;
	logic [MAX_ENTRIES-1:0]     match_d;
	logic [MAX_ENTRIES-1:0]     victim_d;

	logic [EW-1:0]              cap_ext;
	logic [EW-1:0]              eff_cap;
	logic                       room;
	logic                       hit_any;
	logic [IDX_W-1:0]           hit_idx;
	logic [IDX_W-1:0]           vic_idx;
	logic [IDX_W-1:0]           old_rank;
	logic [lsc_pkg::KEY_W-1:0]  vic_key;
	logic                       is_get;
	logic                       put_new;
	logic                       get_hit;
	logic [IDX_W-1:0]           new_idx;
	logic [IDX_W-1:0]           tgt_idx;
	logic [lsc_pkg::DATA_W-1:0] ram_rdata;

	// occupancy and LRU candidate from the current fill
	assign last_rank = IDX_W'(fill_q - CNT_W'(1));

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			occ[i]      = CNT_W'(i) < fill_q;
			match_d[i]  = occ[i] && (keys_q[i] == key);
			victim_d[i] = occ[i] && (ranks_q[i] == last_rank);
		end
	end

	// effective capacity, clamped to 1..MAX_ENTRIES
	assign cap_ext = EW'(capacity_q);

	always_comb begin
		if (cap_ext == EW'(0)) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(MAX_ENTRIES)) begin
			eff_cap = EW'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign room = EW'(fill_q) < eff_cap;

	always_comb begin
		hit_idx  = '0;
		vic_idx  = '0;
		old_rank = '0;
		vic_key  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match_s1[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				old_rank = old_rank | ranks_q[i];
			end
			if (victim_s1[i]) begin
				vic_idx = vic_idx | IDX_W'(i);
				vic_key = vic_key | keys_q[i];
			end
		end
	end

	assign hit_any = |match_s1;
	assign is_get  = (req_type_q == lsc_pkg::REQ_GET);
	assign put_new = !is_get && !hit_any;
	assign get_hit = is_get && hit_any;
	assign new_idx = room ? IDX_W'(fill_q) : vic_idx;
	assign tgt_idx = put_new ? new_idx : hit_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lsc_pkg::CAP_RESET;
			fill_q     <= '0;
		end else begin
			if (cfg_we) capacity_q <= cfg_wdata;
			if (cmd.exec && put_new && room) fill_q <= fill_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			key_q      <= key;
			value_q    <= value;
			match_s1   <= match_d;
			victim_s1  <= victim_d;
		end
		if (cmd.exec) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (put_new || get_hit) begin
					if (IDX_W'(i) == tgt_idx) begin
						ranks_q[i] <= '0;
					end else if (occ[i] && (put_new || ranks_q[i] < old_rank)) begin
						ranks_q[i] <= ranks_q[i] + IDX_W'(1);
					end
				end
			end
			if (put_new) keys_q[new_idx] <= key_q;
			hit_s2     <= hit_any;
			get_hit_s2 <= get_hit;
			slot_s2    <= (put_new || hit_any) ? lsc_pkg::SLOT_W'(tgt_idx) : '0;
			evicted_s2 <= put_new && !room;
			evkey_s2   <= (put_new && !room) ? vic_key : '0;
		end
		if (cmd.load) begin
			hit         <= hit_s2;
			slot        <= slot_s2;
			read_data   <= get_hit_s2 ? ram_rdata : '0;
			evicted     <= evicted_s2;
			evicted_key <= evkey_s2;
		end
	end

	lsc_ram #(
		.WIDTH(lsc_pkg::DATA_W),
		.DEPTH(MAX_ENTRIES)
	) u_data_ram (
		.clk  (clk),
		.we   (cmd.exec && put_new),
		.waddr(new_idx),
		.wdata(value_q),
		.re   (cmd.exec && get_hit),
		.raddr(hit_idx),
		.rdata(ram_rdata)
	);

endmodule

// File: rtl/core/lru_slot_cache_top.sv
// LRU slot cache: the match is taken at accept, then the execute state updates ranks,
// keys, fill and the data RAM, and the response loads the output register; the RAM read
// lands with the response. A next request is accepted in the response state.
// A stalled output holds the next accept until the output register is free.
// Reset clears fill count and capacity (to 16); slot keys, ranks and data stay unset.
`timescale 1ns / 1ps
module lru_slot_cache_top #(
	parameter int MAX_ENTRIES = lsc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lsc_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic [lsc_pkg::KEY_W-1:0]  key,
	input  logic [lsc_pkg::DATA_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       hit,
	output logic [lsc_pkg::SLOT_W-1:0] slot,
	output logic [lsc_pkg::DATA_W-1:0] read_data,
	output logic                       evicted,
	output logic [lsc_pkg::KEY_W-1:0]  evicted_key
);

	lsc_pkg::lsc_cmd_t cmd;

	lsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	lsc_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.key        (key),
		.value      (value),
		.hit        (hit),
		.slot       (slot),
		.read_data  (read_data),
		.evicted    (evicted),
		.evicted_key(evicted_key)
	);

endmodule

// File: bench/tb.sv
// Self-checking testbench for lru_slot_cache_top: shadow LRU model with random stalls.
`timescale 1ns / 1ps
module tb;

	localparam int STALL_LIMIT = 1000;
	localparam int N_PHASES    = 11;
	localparam int PHASE_ITEMS = 160;

	typedef struct packed {
		logic                       req;
		logic [lsc_pkg::KEY_W-1:0]  key;
		logic [lsc_pkg::DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                       hit;
		logic [lsc_pkg::SLOT_W-1:0] slot;
		logic [lsc_pkg::DATA_W-1:0] read_data;
		logic                       evicted;
		logic [lsc_pkg::KEY_W-1:0]  evicted_key;
	} resp_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [lsc_pkg::CAP_W-1:0]  cfg_wdata = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       req_type = 1'b0;
	logic [lsc_pkg::KEY_W-1:0]  key = '0;
	logic [lsc_pkg::DATA_W-1:0] value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       hit;
	logic [lsc_pkg::SLOT_W-1:0] slot;
	logic [lsc_pkg::DATA_W-1:0] read_data;
	logic                       evicted;
	logic [lsc_pkg::KEY_W-1:0]  evicted_key;

	req_t  pending[$];
	resp_t resp_due[$];
	logic [lsc_pkg::KEY_W-1:0] key_pool[$];

	logic [lsc_pkg::KEY_W-1:0]  shadow_key[lsc_pkg::MAX_ENTRIES_DEF];
	logic [lsc_pkg::DATA_W-1:0] shadow_data[lsc_pkg::MAX_ENTRIES_DEF];
	logic [lsc_pkg::SLOT_W-1:0] shadow_rank[lsc_pkg::MAX_ENTRIES_DEF];
	logic [lsc_pkg::CAP_W-1:0]  shadow_fill = '0;
	logic [lsc_pkg::CAP_W-1:0]  shadow_cap = lsc_pkg::CAP_RESET;

	int  mismatches = 0;
	int  stall_cycles = 0;
	int  in_gap = 0;
	int  out_gap = 0;
	bit  in_burst = 1'b0;
	bit  out_burst = 1'b0;
	int  phase_cap[N_PHASES];

	lru_slot_cache_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .slot(slot), .read_data(read_data),
		.evicted(evicted), .evicted_key(evicted_key)
	);

	always #5 clk = ~clk;

	function automatic void make_recent(int s);
		logic [lsc_pkg::SLOT_W-1:0] old_rank;
		old_rank = shadow_rank[s];
		for (int i = 0; i < shadow_fill; i++)
			if (i != s && shadow_rank[i] < old_rank)
				shadow_rank[i] = shadow_rank[i] + 1'b1;
		shadow_rank[s] = '0;
	endfunction

	function automatic resp_t lru_access(req_t r);
		resp_t o;
		int    m;
		int    s;
		int    eff_cap;
		o = '0;
		m = -1;
		for (int i = 0; i < shadow_fill; i++)
			if (m < 0 && shadow_key[i] == r.key)
				m = i;
		eff_cap = (shadow_cap == 0) ? 1 :
			(shadow_cap > lsc_pkg::MAX_ENTRIES_DEF) ? lsc_pkg::MAX_ENTRIES_DEF :
			int'(shadow_cap);
		if (r.req == lsc_pkg::REQ_GET) begin
			if (m >= 0) begin
				o.hit = 1'b1;
				o.slot = m[lsc_pkg::SLOT_W-1:0];
				o.read_data = shadow_data[m];
				make_recent(m);
			end
		end else if (m >= 0) begin
			o.hit = 1'b1;
			o.slot = m[lsc_pkg::SLOT_W-1:0];
		end else begin
			if (shadow_fill < eff_cap) begin
				s = int'(shadow_fill);
				shadow_fill = shadow_fill + 1'b1;
				shadow_rank[s] = s[lsc_pkg::SLOT_W-1:0];
			end else begin
				s = 0;
				for (int i = 1; i < shadow_fill; i++)
					if (shadow_rank[i] > shadow_rank[s])
						s = i;
				o.evicted = 1'b1;
				o.evicted_key = shadow_key[s];
			end
			shadow_key[s] = r.key;
			shadow_data[s] = r.value;
			make_recent(s);
			o.slot = s[lsc_pkg::SLOT_W-1:0];
		end
		return o;
	endfunction

	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// request driver
	always @(posedge clk) begin
		req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				resp_due.push_back(lru_access('{req_type, key, value}));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					nxt = pending.pop_front();
					in_valid <= 1'b1;
					req_type <= nxt.req;
					key <= nxt.key;
					value <= nxt.value;
					in_gap <= pick_gap(in_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		resp_t e;
		int    g;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (resp_due.size() == 0) begin
					$error("result beat with nothing expected");
					mismatches++;
				end else begin
					e = resp_due.pop_front();
					if (hit !== e.hit) begin
						$error("hit: expected %0h, got %0h", e.hit, hit);
						mismatches++;
					end
					if (slot !== e.slot) begin
						$error("slot: expected %0h, got %0h", e.slot, slot);
						mismatches++;
					end
					if (read_data !== e.read_data) begin
						$error("read_data: expected %0h, got %0h", e.read_data, read_data);
						mismatches++;
					end
					if (evicted !== e.evicted) begin
						$error("evicted: expected %0h, got %0h", e.evicted, evicted);
						mismatches++;
					end
					if (evicted_key !== e.evicted_key) begin
						$error("evicted_key: expected %0h, got %0h",
							e.evicted_key, evicted_key);
						mismatches++;
					end
				end
				g = pick_gap(out_burst);
				out_gap <= g;
				out_ready <= (g == 0);
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= (out_gap == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic add_item(logic r, logic [lsc_pkg::KEY_W-1:0] k,
		logic [lsc_pkg::DATA_W-1:0] v);
		pending.push_back('{r, k, v});
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (pending.size() != 0 || in_valid || resp_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cap(int c);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c[lsc_pkg::CAP_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cap = c[lsc_pkg::CAP_W-1:0];
		@(negedge clk);
	endtask

	task automatic add_random(int n);
		int r;
		int eff_cap;
		logic [lsc_pkg::KEY_W-1:0] k;
		eff_cap = (shadow_cap == 0) ? 1 :
			(shadow_cap > lsc_pkg::MAX_ENTRIES_DEF) ? lsc_pkg::MAX_ENTRIES_DEF :
			int'(shadow_cap);
		key_pool.delete();
		repeat (eff_cap + $urandom_range(0, 4)) begin
			r = $urandom_range(0, 19);
			key_pool.push_back(r == 0 ? '0 : r == 1 ? '1 : $urandom);
		end
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
				add_item(1'($urandom_range(0, 1)), k, {$urandom, $urandom});
			end else begin
				add_item(r < 85 ? lsc_pkg::REQ_GET : lsc_pkg::REQ_PUT, $urandom,
					{$urandom, $urandom});
			end
		end
	endtask

	initial begin
		phase_cap = '{1, 0, 31, 2, 16, 5, 17, 8, 3, 12, 16};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty cache, key and data extremes, put hit, get miss
		add_item(lsc_pkg::REQ_GET, 32'h0, 64'h0);
		add_item(lsc_pkg::REQ_PUT, 32'h0, 64'h0);
		add_item(lsc_pkg::REQ_PUT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(lsc_pkg::REQ_GET, 32'h0, 64'h0);
		add_item(lsc_pkg::REQ_GET, 32'hFFFF_FFFF, 64'h0);
		add_item(lsc_pkg::REQ_PUT, 32'h0, 64'h1234_5678_9ABC_DEF0);
		add_item(lsc_pkg::REQ_GET, 32'h0, 64'h0);
		add_item(lsc_pkg::REQ_GET, 32'h5A5A_A5A5, 64'hFFFF_FFFF_FFFF_FFFF);
		settle();

		// small capacity: fill, then evict least recent
		write_cap(3);
		add_item(lsc_pkg::REQ_PUT, 32'h1111_1111, 64'hAAAA_AAAA_AAAA_AAAA);
		add_item(lsc_pkg::REQ_PUT, 32'h2222_2222, 64'h5555_5555_5555_5555);
		add_item(lsc_pkg::REQ_GET, 32'h0, 64'h0);
		add_item(lsc_pkg::REQ_PUT, 32'h3333_3333, 64'h0F0F_0F0F_0F0F_0F0F);
		add_item(lsc_pkg::REQ_GET, 32'h2222_2222, 64'h0);
		add_item(lsc_pkg::REQ_GET, 32'hFFFF_FFFF, 64'h0);
		add_item(lsc_pkg::REQ_PUT, 32'h1111_1111, 64'h0);
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			write_cap(phase_cap[p]);
			in_burst = ($urandom_range(0, 3) == 0);
			out_burst = ($urandom_range(0, 3) == 0);
			add_random(PHASE_ITEMS);
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
